>>> sv/slist_pkg.sv
// shared types, sizes and codes for the sorted list block
package slist_pkg;

    // node pool size; slot 0 is the null link
    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int IDX_W      = $clog2(POOL_SLOTS);
    localparam int STEP_W     = $clog2(POOL_SLOTS + 1);
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;

    // stream widths
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - SLOT_W - VALUE_W;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_ITEM     = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DUMP   = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_PLACE,
        ST_WALK_FIRST,
        ST_WALK,
        ST_LINK_PREV,
        ST_LINK_NEW,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_EMIT
    } state_t;

    // node memory access from the controller
    typedef struct packed {
        logic   val_re;
        slot_t  val_raddr;
        logic   val_we;
        slot_t  val_waddr;
        value_t val_wdata;
        logic   link_re;
        slot_t  link_raddr;
        logic   link_we;
        slot_t  link_waddr;
        slot_t  link_wdata;
    } mem_req_t;

    typedef struct packed {
        value_t val_rdata;
        slot_t  link_rdata;
    } mem_rsp_t;

    // link held by a slot right after reset: all usable slots chained free
    function automatic slot_t init_link(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        if ((idx != '0) && (int'(idx) < POOL_SLOTS - 1)) begin
            return slot_t'(nxt);
        end
        return '0;
    endfunction

endpackage

>>> sv/slist_node_mem.sv
// node value and link memories, one read and one write port each, registered reads
module slist_node_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  slist_pkg::mem_req_t mem_req,
    output slist_pkg::mem_rsp_t mem_rsp
);
    import slist_pkg::*;

    value_t                  val_mem  [POOL_SLOTS];
    slot_t                   link_mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0]   link_vld_reg;

    value_t                  val_q_reg;
    slot_t                   link_q_reg;
    slot_t                   link_init_reg;
    logic                    link_hit_reg;

    logic [IDX_W-1:0]        val_ra;
    logic [IDX_W-1:0]        val_wa;
    logic [IDX_W-1:0]        link_ra;
    logic [IDX_W-1:0]        link_wa;

    assign val_ra  = mem_req.val_raddr[IDX_W-1:0];
    assign val_wa  = mem_req.val_waddr[IDX_W-1:0];
    assign link_ra = mem_req.link_raddr[IDX_W-1:0];
    assign link_wa = mem_req.link_waddr[IDX_W-1:0];

    // value memory
    always_ff @(posedge aclk) begin
        if (mem_req.val_we) begin
            val_mem[val_wa] <= mem_req.val_wdata;
        end
        if (mem_req.val_re) begin
            val_q_reg <= val_mem[val_ra];
        end
    end

    // link memory; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (mem_req.link_we) begin
            link_mem[link_wa] <= mem_req.link_wdata;
        end
        if (mem_req.link_re) begin
            link_q_reg    <= link_mem[link_ra];
            link_init_reg <= init_link(link_ra);
            link_hit_reg  <= link_vld_reg[link_ra];
        end
    end

    // written marks; an unwritten link reads as its free chain value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (mem_req.link_we) begin
            link_vld_reg[link_wa] <= 1'b1;
        end
    end

    assign mem_rsp.val_rdata  = val_q_reg;
    assign mem_rsp.link_rdata = link_hit_reg ? link_q_reg : link_init_reg;

endmodule

>>> sv/slist_ctrl.sv
// list controller: free list pop, sorted walk, relinking, dump and output register
module slist_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [slist_pkg::S_TDATA_W-1:0] s_tdata,   // value
    input  logic                            s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [slist_pkg::M_TDATA_W-1:0] m_tdata,   // slot, item_value, zero pad
    output logic [slist_pkg::STATUS_W-1:0]  m_tuser,   // status
    output logic                            m_tlast,
    output slist_pkg::mem_req_t             mem_req,
    input  slist_pkg::mem_rsp_t             mem_rsp
);
    import slist_pkg::*;

    state_t  state_reg,      state_next;
    slot_t   head_reg,       head_next;
    slot_t   tail_reg,       tail_next;
    slot_t   free_reg,       free_next;
    value_t  head_val_reg,   head_val_next;
    value_t  tail_val_reg,   tail_val_next;
    value_t  value_reg,      value_next;
    slot_t   new_slot_reg,   new_slot_next;
    slot_t   prev_reg,       prev_next;
    slot_t   cur_reg,        cur_next;
    step_t   steps_reg,      steps_next;
    status_t pend_reg,       pend_next;
    logic    out_valid_reg,  out_valid_next;
    status_t out_status_reg, out_status_next;
    slot_t   out_slot_reg,   out_slot_next;
    value_t  out_value_reg,  out_value_next;
    logic    out_last_reg,   out_last_next;

    logic    out_free;
    logic    dump_fin;
    value_t  rd_val;
    slot_t   rd_link;

    assign rd_val   = mem_rsp.val_rdata;
    assign rd_link  = mem_rsp.link_rdata;
    assign out_free = !out_valid_reg || m_tready;
    assign dump_fin = (rd_link == '0) || (steps_reg == step_t'(POOL_SLOTS - 2));

    // next state, memory requests and output loading
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        head_val_next   = head_val_reg;
        tail_val_next   = tail_val_reg;
        value_next      = value_reg;
        new_slot_next   = new_slot_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        mem_req         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    value_next = value_t'(s_tdata);
                    if (opcode_t'(s_tuser) == OP_DUMP) begin
                        if (head_reg == '0) begin
                            pend_next     = STAT_EMPTY;
                            new_slot_next = '0;
                            value_next    = '0;
                            state_next    = ST_EMIT;
                        end else begin
                            cur_next   = head_reg;
                            steps_next = '0;
                            state_next = ST_DUMP_RD;
                        end
                    end else if (free_reg == '0) begin
                        pend_next     = STAT_FULL;
                        new_slot_next = '0;
                        state_next    = ST_EMIT;
                    end else begin
                        pend_next     = STAT_INSERTED;
                        new_slot_next = free_reg;
                        state_next    = ST_POP;
                    end
                end
            end
            // fetch the link of the slot taken off the free list
            ST_POP: begin
                mem_req.link_re    = 1'b1;
                mem_req.link_raddr = new_slot_reg;
                state_next         = ST_PLACE;
            end
            // store the value and pick head, tail or walk
            ST_PLACE: begin
                free_next         = rd_link;
                mem_req.val_we    = 1'b1;
                mem_req.val_waddr = new_slot_reg;
                mem_req.val_wdata = value_reg;
                if (head_reg == '0) begin
                    head_next     = new_slot_reg;
                    tail_next     = new_slot_reg;
                    head_val_next = value_reg;
                    tail_val_next = value_reg;
                    cur_next      = '0;
                    state_next    = ST_LINK_NEW;
                end else if (!(head_val_reg < value_reg)) begin
                    cur_next      = head_reg;
                    head_next     = new_slot_reg;
                    head_val_next = value_reg;
                    state_next    = ST_LINK_NEW;
                end else if (tail_val_reg < value_reg) begin
                    prev_next  = tail_reg;
                    cur_next   = '0;
                    state_next = ST_LINK_PREV;
                end else begin
                    mem_req.link_re    = 1'b1;
                    mem_req.link_raddr = head_reg;
                    prev_next          = head_reg;
                    steps_next         = '0;
                    state_next         = ST_WALK_FIRST;
                end
            end
            // first node after the head
            ST_WALK_FIRST: begin
                cur_next = rd_link;
                if (rd_link == '0) begin
                    state_next = ST_LINK_PREV;
                end else begin
                    mem_req.link_re    = 1'b1;
                    mem_req.link_raddr = rd_link;
                    mem_req.val_re     = 1'b1;
                    mem_req.val_raddr  = rd_link;
                    state_next         = ST_WALK;
                end
            end
            // one link per cycle while the node value is smaller
            ST_WALK: begin
                if ((rd_val < value_reg) && (steps_reg < step_t'(POOL_SLOTS))) begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    steps_next = steps_reg + 1'b1;
                    if (rd_link == '0) begin
                        state_next = ST_LINK_PREV;
                    end else begin
                        mem_req.link_re    = 1'b1;
                        mem_req.link_raddr = rd_link;
                        mem_req.val_re     = 1'b1;
                        mem_req.val_raddr  = rd_link;
                    end
                end else begin
                    state_next = ST_LINK_PREV;
                end
            end
            // predecessor points at the new node
            ST_LINK_PREV: begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = prev_reg;
                mem_req.link_wdata = new_slot_reg;
                if (cur_reg == '0) begin
                    tail_next     = new_slot_reg;
                    tail_val_next = value_reg;
                end
                state_next = ST_LINK_NEW;
            end
            // new node points at its successor
            ST_LINK_NEW: begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = new_slot_reg;
                mem_req.link_wdata = cur_reg;
                state_next         = ST_EMIT;
            end
            ST_DUMP_RD: begin
                mem_req.link_re    = 1'b1;
                mem_req.link_raddr = cur_reg;
                mem_req.val_re     = 1'b1;
                mem_req.val_raddr  = cur_reg;
                state_next         = ST_DUMP_OUT;
            end
            // one dump beat per node, next reads issued as the beat is loaded
            ST_DUMP_OUT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_ITEM;
                    out_slot_next   = cur_reg;
                    out_value_next  = rd_val;
                    out_last_next   = dump_fin;
                    if (dump_fin) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next           = rd_link;
                        steps_next         = steps_reg + 1'b1;
                        mem_req.link_re    = 1'b1;
                        mem_req.link_raddr = rd_link;
                        mem_req.val_re     = 1'b1;
                        mem_req.val_raddr  = rd_link;
                    end
                end
            end
            // single result beat of an insert or an empty dump
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_reg;
                    out_slot_next   = new_slot_reg;
                    out_value_next  = value_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= slot_t'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        head_val_reg   <= head_val_next;
        tail_val_reg   <= tail_val_next;
        value_reg      <= value_next;
        new_slot_reg   <= new_slot_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        pend_reg       <= pend_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_value_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // head and tail are empty together
    a_head_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == '0) == (tail_reg == '0))
        else $error("head and tail disagree on empty list");

    // the walk never compares at the null slot
    a_walk_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (cur_reg != '0))
        else $error("walk reached null slot");

    // the null slot is never relinked
    a_link_null: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.link_we |-> (mem_req.link_waddr != '0))
        else $error("link write to null slot");

    // one item at a time: ready drops after an accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while busy");

endmodule

>>> sv/sorted_list_insert_with_free_list_top.sv
// top level of the sorted linked list with free list over a node pool memory
// insert: pop and place, then link new at the head, link previous and new at the tail, or a
// walk and both links; a full pool or an empty dump goes from accept straight to the result state
// dump: a read state, then one beat per cycle per node while taken, bound by the link read
// one item in work at a time; the next beat is taken while the last result still waits
// reset clears head and tail, sets the free head to slot 1, marks every link unwritten (pool all free)
module sorted_list_insert_with_free_list_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [slist_pkg::S_TDATA_W-1:0] s_tdata,   // value
    input  logic                            s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [slist_pkg::M_TDATA_W-1:0] m_tdata,   // slot, item_value, zero pad
    output logic [slist_pkg::STATUS_W-1:0]  m_tuser,   // status
    output logic                            m_tlast
);
    import slist_pkg::*;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    // walk, relink and dump sequencing
    slist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .mem_req  (mem_req),
        .mem_rsp  (mem_rsp)
    );

    // node pool storage
    slist_node_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mem_req  (mem_req),
        .mem_rsp  (mem_rsp)
    );

endmodule
